/* rtl/smfr_pkg.sv */
// Package for the slot message frame reassembler.
// Sizes, address widths, state and opcode enums, request/result and RAM port structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smfr_pkg;

  localparam int RAW_FIFO_DEPTH    = 256;
  localparam int FRAME_QUEUE_DEPTH = 8;
  localparam int SLOTS_PER_FRAME   = 9;

  localparam logic [7:0] KIND_SLOT = 8'h20;

  localparam int RAW_AW  = (RAW_FIFO_DEPTH > 1) ? $clog2(RAW_FIFO_DEPTH) : 1;
  localparam int RAW_LW  = $clog2(RAW_FIFO_DEPTH + 1);
  localparam int FQ_AW   = (FRAME_QUEUE_DEPTH > 1) ? $clog2(FRAME_QUEUE_DEPTH) : 1;
  localparam int FQ_LW   = $clog2(FRAME_QUEUE_DEPTH + 1);
  localparam int SLOT_W  = $clog2(SLOTS_PER_FRAME);
  localparam int SCNT_W  = $clog2(SLOTS_PER_FRAME + 1);

  // frame RAM: current frame, staged frame, then the queue slots
  localparam int FRM_DEPTH = SLOTS_PER_FRAME * (FRAME_QUEUE_DEPTH + 2);
  localparam int FRM_AW    = $clog2(FRM_DEPTH);
  localparam int CUR_BASE  = 0;
  localparam int STG_BASE  = SLOTS_PER_FRAME;
  localparam int Q_BASE    = 2 * SLOTS_PER_FRAME;

  typedef enum logic [1:0] {
    OP_RX_BYTE     = 2'd0,
    OP_CYCLE_START = 2'd1,
    OP_READ_POS    = 2'd2,
    OP_POP_RAW     = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_READ,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] rx_byte;
    logic [3:0] position;
  } request_t;

  typedef struct packed {
    logic        value_valid;
    logic [15:0] value;
    logic        staged_is_fill;
    logic [8:0]  rx_level;
    logic [3:0]  frames_queued;
    logic [31:0] seq_gap_count;
    logic [31:0] frames_dropped_count;
    logic [31:0] recv_overrun_count;
    logic [31:0] fill_frame_count;
    logic [31:0] popped_count;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [RAW_AW-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [RAW_AW-1:0] raddr;
  } raw_req_t;

  typedef struct packed {
    logic              we;
    logic [FRM_AW-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [FRM_AW-1:0] raddr;
  } frm_req_t;

  function automatic logic [FRM_AW-1:0] q_base(input logic [FQ_AW-1:0] slot);
    q_base = FRM_AW'(Q_BASE) + FRM_AW'(slot) * FRM_AW'(SLOTS_PER_FRAME);
  endfunction

endpackage

`default_nettype wire

/* rtl/smfr_if.sv */
// Channel interfaces of the reassembler: request channel and result channel.
// Valid/ready handshake with payload; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface smfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;
  logic [3:0] position;

  modport source (output valid, opcode, rx_byte, position, input ready);
  modport sink   (input valid, opcode, rx_byte, position, output ready);
endinterface

interface smfr_out_if;
  logic        valid;
  logic        ready;
  logic        value_valid;
  logic [15:0] value;
  logic        staged_is_fill;
  logic [8:0]  rx_level;
  logic [3:0]  frames_queued;
  logic [31:0] seq_gap_count;
  logic [31:0] frames_dropped_count;
  logic [31:0] recv_overrun_count;
  logic [31:0] fill_frame_count;
  logic [31:0] popped_count;

  modport source (output valid, value_valid, value, staged_is_fill, rx_level, frames_queued,
                  seq_gap_count, frames_dropped_count, recv_overrun_count,
                  fill_frame_count, popped_count, input ready);
  modport sink   (input valid, value_valid, value, staged_is_fill, rx_level, frames_queued,
                  seq_gap_count, frames_dropped_count, recv_overrun_count,
                  fill_frame_count, popped_count, output ready);
endinterface

`default_nettype wire

/* rtl/slot_message_frame_reassembler_unit.sv */
// Bytes and cycle starts go straight to the result; a pop or staged read first waits for the
// registered RAM read data; a read that stages a queued frame, and a byte that completes a
// frame, first copy the frame slot by slot (through the single frame RAM port pair). A new item
// is accepted only while the sequencer is idle; the output register lets the next item be
// accepted while a result waits. Reset clears the state, pointers, levels, flags and counters
// at once; RAM contents are undefined until written and need no clearing pass.
// Top level: instantiates smfr_ctrl and two smfr_ram; depends on smfr_pkg and smfr_if.
`timescale 1ns / 1ps
`default_nettype none

module slot_message_frame_reassembler_unit import smfr_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  smfr_in_if.sink     in_i,
  smfr_out_if.source  out_o
);

  request_t    req;
  result_t     res, out_q;
  logic        res_valid, res_ready, out_valid_q;
  raw_req_t    raw_req;
  frm_req_t    frm_req;
  logic [15:0] raw_rdata, frm_rdata;

  always_comb begin
    req.opcode   = opcode_e'(in_i.opcode);
    req.rx_byte  = in_i.rx_byte;
    req.position = in_i.position;
  end

  smfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (in_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .raw_req_o   (raw_req),
    .raw_rdata_i (raw_rdata),
    .frm_req_o   (frm_req),
    .frm_rdata_i (frm_rdata)
  );

  smfr_ram #(.WIDTH(16), .DEPTH(RAW_FIFO_DEPTH)) u_raw_ram (
    .clk_i   (clk_i),
    .we_i    (raw_req.we),
    .waddr_i (raw_req.waddr),
    .wdata_i (raw_req.wdata),
    .re_i    (raw_req.re),
    .raddr_i (raw_req.raddr),
    .rdata_o (raw_rdata)
  );

  smfr_ram #(.WIDTH(16), .DEPTH(FRM_DEPTH)) u_frm_ram (
    .clk_i   (clk_i),
    .we_i    (frm_req.we),
    .waddr_i (frm_req.waddr),
    .wdata_i (frm_req.wdata),
    .re_i    (frm_req.re),
    .raddr_i (frm_req.raddr),
    .rdata_o (frm_rdata)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  always_comb begin
    out_o.valid                = out_valid_q;
    out_o.value_valid          = out_q.value_valid;
    out_o.value                = out_q.value;
    out_o.staged_is_fill       = out_q.staged_is_fill;
    out_o.rx_level             = out_q.rx_level;
    out_o.frames_queued        = out_q.frames_queued;
    out_o.seq_gap_count        = out_q.seq_gap_count;
    out_o.frames_dropped_count = out_q.frames_dropped_count;
    out_o.recv_overrun_count   = out_q.recv_overrun_count;
    out_o.fill_frame_count     = out_q.fill_frame_count;
    out_o.popped_count         = out_q.popped_count;
  end

endmodule

`default_nettype wire

/* rtl/smfr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module smfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/smfr_ctrl.sv */
// Sequencer of the reassembler: message assembly, FIFO and frame queue pointers,
// counters and the frame copy engine. Depends on smfr_pkg; drives both RAMs.
`timescale 1ns / 1ps
`default_nettype none

module smfr_ctrl import smfr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  input  wire request_t req_i,
  output logic          res_valid_o,
  input  wire logic     res_ready_i,
  output result_t       res_o,
  output raw_req_t      raw_req_o,
  input  wire logic [15:0] raw_rdata_i,
  output frm_req_t      frm_req_o,
  input  wire logic [15:0] frm_rdata_i
);

  state_e              state_q, state_d;
  logic [7:0]          msg_q [4];
  logic [7:0]          msg_d [4];
  logic [2:0]          msg_cnt_q, msg_cnt_d;
  logic [7:0]          exp_seq_q, exp_seq_d;
  logic [RAW_AW-1:0]   raw_head_q, raw_head_d, raw_tail_q, raw_tail_d;
  logic [RAW_LW-1:0]   raw_level_q, raw_level_d;
  logic [SLOTS_PER_FRAME-1:0] mask_q, mask_d;
  logic [FQ_AW-1:0]    fq_head_q, fq_head_d;
  logic [FQ_LW-1:0]    fq_level_q, fq_level_d;
  logic                fill_q, fill_d, loaded_q, loaded_d;
  logic [31:0]         gap_q, gap_d, drop_q, drop_d, ovr_q, ovr_d;
  logic [31:0]         fcnt_q, fcnt_d, pop_q, pop_d;
  logic [SCNT_W-1:0]   cnt_q, cnt_d;
  logic [FRM_AW-1:0]   src_q, src_d, dst_q, dst_d;
  logic [3:0]          pos_q, pos_d;
  logic                ret_read_q, ret_read_d;
  logic                rd_raw_q, rd_raw_d;
  logic                vvalid_q, vvalid_d;
  logic [15:0]         value_q, value_d;

  logic [7:0]          pos8, seq8;
  logic [15:0]         slot_val;
  logic                in_range, prefix_ok, is_last, mask_full, pos_ok;
  logic [SLOTS_PER_FRAME-1:0] need;
  logic [SLOT_W-1:0]   pos_idx;
  logic [RAW_AW-1:0]   raw_head_inc, raw_tail_inc;
  logic [FQ_AW-1:0]    fq_head_inc, fq_slot;
  logic [FQ_LW:0]      fq_sum;

  always_comb begin
    pos8      = msg_q[1];
    seq8      = msg_q[2];
    slot_val  = {msg_q[3], req_i.rx_byte};
    in_range  = pos8 < 8'(SLOTS_PER_FRAME);
    pos_idx   = pos8[SLOT_W-1:0];
    is_last   = pos8 == 8'(SLOTS_PER_FRAME - 1);
    mask_full = &mask_q;
    for (int k = 0; k < SLOTS_PER_FRAME; k++) begin
      need[k] = 8'(k) < pos8;
    end
    prefix_ok    = (mask_q & need) == need;
    raw_head_inc = (raw_head_q == RAW_AW'(RAW_FIFO_DEPTH - 1)) ? '0 : raw_head_q + 1'b1;
    raw_tail_inc = (raw_tail_q == RAW_AW'(RAW_FIFO_DEPTH - 1)) ? '0 : raw_tail_q + 1'b1;
    fq_head_inc  = (fq_head_q == FQ_AW'(FRAME_QUEUE_DEPTH - 1)) ? '0 : fq_head_q + 1'b1;
    fq_sum       = (FQ_LW+1)'(fq_head_q) + (FQ_LW+1)'(fq_level_q);
    fq_slot      = (fq_sum >= (FQ_LW+1)'(FRAME_QUEUE_DEPTH))
                 ? FQ_AW'(fq_sum - (FQ_LW+1)'(FRAME_QUEUE_DEPTH)) : FQ_AW'(fq_sum);
    pos_ok       = {1'b0, req_i.position} < 5'(SLOTS_PER_FRAME);
  end

  always_comb begin
    state_d    = state_q;
    msg_d      = msg_q;
    msg_cnt_d  = msg_cnt_q;
    exp_seq_d  = exp_seq_q;
    raw_head_d = raw_head_q;
    raw_tail_d = raw_tail_q;
    raw_level_d = raw_level_q;
    mask_d     = mask_q;
    fq_head_d  = fq_head_q;
    fq_level_d = fq_level_q;
    fill_d     = fill_q;
    loaded_d   = loaded_q;
    gap_d      = gap_q;
    drop_d     = drop_q;
    ovr_d      = ovr_q;
    fcnt_d     = fcnt_q;
    pop_d      = pop_q;
    cnt_d      = cnt_q;
    src_d      = src_q;
    dst_d      = dst_q;
    pos_d      = pos_q;
    ret_read_d = ret_read_q;
    rd_raw_d   = rd_raw_q;
    vvalid_d   = vvalid_q;
    value_d    = value_q;
    raw_req_o  = '0;
    frm_req_o  = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          vvalid_d = 1'b0;
          value_d  = '0;
          state_d  = ST_DONE;
          case (req_i.opcode)
            OP_RX_BYTE: begin
              if (msg_cnt_q != 3'd4) begin
                msg_d[msg_cnt_q[1:0]] = req_i.rx_byte;
                msg_cnt_d = msg_cnt_q + 3'd1;
              end else begin
                msg_cnt_d = '0;
                if (msg_q[0] == KIND_SLOT) begin
                  if (seq8 != exp_seq_q) begin
                    gap_d = gap_q + 32'd1;
                  end
                  exp_seq_d = seq8 + 8'd1;
                  raw_req_o.we    = 1'b1;
                  raw_req_o.waddr = raw_head_q;
                  raw_req_o.wdata = slot_val;
                  raw_head_d = raw_head_inc;
                  if (raw_level_q == RAW_LW'(RAW_FIFO_DEPTH)) begin
                    raw_tail_d = raw_tail_inc;
                    ovr_d = ovr_q + 32'd1;
                  end else begin
                    raw_level_d = raw_level_q + 1'b1;
                  end
                  if (!in_range) begin
                    drop_d = drop_q + 32'd1;
                  end else if (pos8 == 8'd0) begin
                    if (!mask_full) begin
                      drop_d = drop_q + 32'd1;
                    end
                    frm_req_o.we    = 1'b1;
                    frm_req_o.waddr = FRM_AW'(CUR_BASE);
                    frm_req_o.wdata = slot_val;
                    mask_d = SLOTS_PER_FRAME'(1);
                  end else if (!prefix_ok) begin
                    drop_d = drop_q + 32'd1;
                  end else begin
                    frm_req_o.we    = 1'b1;
                    frm_req_o.waddr = FRM_AW'(CUR_BASE) + FRM_AW'(pos_idx);
                    frm_req_o.wdata = slot_val;
                    mask_d = mask_q | (SLOTS_PER_FRAME'(1) << pos_idx);
                    if (is_last) begin
                      if (fq_level_q == FQ_LW'(FRAME_QUEUE_DEPTH)) begin
                        fq_head_d = fq_head_inc;
                        drop_d = drop_q + 32'd1;
                      end else begin
                        fq_level_d = fq_level_q + 1'b1;
                      end
                      src_d      = FRM_AW'(CUR_BASE);
                      dst_d      = q_base(fq_slot);
                      cnt_d      = '0;
                      ret_read_d = 1'b0;
                      state_d    = ST_COPY;
                    end
                  end
                end
              end
            end
            OP_CYCLE_START: begin
              loaded_d = 1'b0;
            end
            OP_READ_POS: begin
              pos_d = req_i.position;
              if (!loaded_q) begin
                loaded_d = 1'b1;
                if (fq_level_q != '0) begin
                  src_d      = q_base(fq_head_q);
                  dst_d      = FRM_AW'(STG_BASE);
                  fq_head_d  = fq_head_inc;
                  fq_level_d = fq_level_q - 1'b1;
                  fill_d     = 1'b0;
                  cnt_d      = '0;
                  ret_read_d = 1'b1;
                  state_d    = ST_COPY;
                end else begin
                  fill_d = 1'b1;
                  fcnt_d = fcnt_q + 32'd1;
                end
              end else if (!fill_q && pos_ok) begin
                frm_req_o.re    = 1'b1;
                frm_req_o.raddr = FRM_AW'(STG_BASE) + FRM_AW'(req_i.position[SLOT_W-1:0]);
                rd_raw_d = 1'b0;
                state_d  = ST_WAIT;
              end
            end
            OP_POP_RAW: begin
              if (raw_level_q != '0) begin
                raw_req_o.re    = 1'b1;
                raw_req_o.raddr = raw_tail_q;
                raw_tail_d  = raw_tail_inc;
                raw_level_d = raw_level_q - 1'b1;
                pop_d    = pop_q + 32'd1;
                rd_raw_d = 1'b1;
                state_d  = ST_WAIT;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_COPY: begin
        // read one slot ahead, write the slot read last cycle
        if (cnt_q < SCNT_W'(SLOTS_PER_FRAME)) begin
          frm_req_o.re    = 1'b1;
          frm_req_o.raddr = src_q + FRM_AW'(cnt_q);
        end
        if (cnt_q != '0) begin
          frm_req_o.we    = 1'b1;
          frm_req_o.waddr = dst_q + FRM_AW'(cnt_q) - FRM_AW'(1);
          frm_req_o.wdata = frm_rdata_i;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SCNT_W'(SLOTS_PER_FRAME)) begin
          state_d = ret_read_q ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        state_d = ST_DONE;
        if (!fill_q && ({1'b0, pos_q} < 5'(SLOTS_PER_FRAME))) begin
          frm_req_o.re    = 1'b1;
          frm_req_o.raddr = FRM_AW'(STG_BASE) + FRM_AW'(pos_q[SLOT_W-1:0]);
          rd_raw_d = 1'b0;
          state_d  = ST_WAIT;
        end
      end
      ST_WAIT: begin
        vvalid_d = 1'b1;
        value_d  = rd_raw_q ? raw_rdata_i : frm_rdata_i;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.value_valid          = vvalid_q;
    res_o.value                = value_q;
    res_o.staged_is_fill       = fill_q;
    res_o.rx_level             = 9'(raw_level_q);
    res_o.frames_queued        = 4'(fq_level_q);
    res_o.seq_gap_count        = gap_q;
    res_o.frames_dropped_count = drop_q;
    res_o.recv_overrun_count   = ovr_q;
    res_o.fill_frame_count     = fcnt_q;
    res_o.popped_count         = pop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      msg_cnt_q   <= '0;
      exp_seq_q   <= '0;
      raw_head_q  <= '0;
      raw_tail_q  <= '0;
      raw_level_q <= '0;
      mask_q      <= '0;
      fq_head_q   <= '0;
      fq_level_q  <= '0;
      fill_q      <= 1'b0;
      loaded_q    <= 1'b0;
      gap_q       <= '0;
      drop_q      <= '0;
      ovr_q       <= '0;
      fcnt_q      <= '0;
      pop_q       <= '0;
      cnt_q       <= '0;
      ret_read_q  <= 1'b0;
      rd_raw_q    <= 1'b0;
      vvalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      msg_cnt_q   <= msg_cnt_d;
      exp_seq_q   <= exp_seq_d;
      raw_head_q  <= raw_head_d;
      raw_tail_q  <= raw_tail_d;
      raw_level_q <= raw_level_d;
      mask_q      <= mask_d;
      fq_head_q   <= fq_head_d;
      fq_level_q  <= fq_level_d;
      fill_q      <= fill_d;
      loaded_q    <= loaded_d;
      gap_q       <= gap_d;
      drop_q      <= drop_d;
      ovr_q       <= ovr_d;
      fcnt_q      <= fcnt_d;
      pop_q       <= pop_d;
      cnt_q       <= cnt_d;
      ret_read_q  <= ret_read_d;
      rd_raw_q    <= rd_raw_d;
      vvalid_q    <= vvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    msg_q   <= msg_d;
    src_q   <= src_d;
    dst_q   <= dst_d;
    pos_q   <= pos_d;
    value_q <= value_d;
  end

`ifndef SYNTHESIS
  a_raw_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    raw_level_q <= RAW_LW'(RAW_FIFO_DEPTH))
    else $error("raw FIFO level beyond depth");

  a_fq_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_level_q <= FQ_LW'(FRAME_QUEUE_DEPTH))
    else $error("frame queue level beyond depth");

  a_frm_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frm_req_o.we && frm_req_o.re) |-> (frm_req_o.waddr != frm_req_o.raddr))
    else $error("frame RAM read and write to the same entry");

  a_raw_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(raw_req_o.we && raw_req_o.re))
    else $error("raw FIFO push and pop in one cycle");

  a_wait_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) |-> $past(raw_req_o.re || frm_req_o.re))
    else $error("value capture without a RAM read");
`endif

endmodule

`default_nettype wire
